// ===== hw/rtl/tls_sni_extractor_macros.svh =====
// Assertion macros shared by the SNI extractor RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef TLS_SNI_EXTRACTOR_MACROS_SVH
`define TLS_SNI_EXTRACTOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TSE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error(msg);
`define TSE_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error(msg);
`else
`define TSE_ASSERT(label, clk, rst_n, prop, msg)
`define TSE_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ===== hw/rtl/tsni_pkg.sv =====
// Shared types and constants of the TLS SNI extractor.
// No dependencies.
`timescale 1ns / 1ps

package tsni_pkg;

	// longest name accepted is NAME_LIMIT - 1 bytes
	localparam int NAME_LIMIT = 256;
	localparam int NAME_W     = $clog2(NAME_LIMIT);

	// header checks
	localparam int POS_W            = 6;
	localparam logic [7:0] REC_HANDSHAKE = 8'h16;
	localparam logic [7:0] VER_MAJOR     = 8'h03;
	localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
	localparam logic [POS_W-1:0] POS_REC_TYPE = POS_W'(0);
	localparam logic [POS_W-1:0] POS_VER_MAJ  = POS_W'(1);
	localparam logic [POS_W-1:0] POS_HS_TYPE  = POS_W'(5);
	localparam logic [POS_W-1:0] POS_SID_LEN  = POS_W'(41);
	localparam logic [15:0] SNI_MIN_SIZE = 16'd5;
	localparam logic [15:0] EXT_HDR_SIZE = 16'd4;

	// output queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// per-byte outcome of the parser
	typedef struct packed {
		logic       name_vld;
		logic       verdict_vld;
		logic [7:0] name_byte;
		logic       found;
		logic [7:0] name_length;
	} step_res_t;

	// one result item
	typedef struct packed {
		logic       is_verdict;
		logic [7:0] name_byte;
		logic       found;
		logic [7:0] name_length;
	} out_item_t;

endpackage

// ===== hw/rtl/tsni_parser.sv =====
// ClientHello parse state machine: one payload byte per step.
// Depends on tsni_pkg and tls_sni_extractor_macros.svh.
`timescale 1ns / 1ps
`include "tls_sni_extractor_macros.svh"

module tsni_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                end_of_payload,
	output tsni_pkg::step_res_t res
);

	localparam logic [3:0] PH_HEAD      = 4'd0;
	localparam logic [3:0] PH_SID       = 4'd1;
	localparam logic [3:0] PH_CS_HI     = 4'd2;
	localparam logic [3:0] PH_CS_LO     = 4'd3;
	localparam logic [3:0] PH_CS        = 4'd4;
	localparam logic [3:0] PH_COMPLEN   = 4'd5;
	localparam logic [3:0] PH_COMP      = 4'd6;
	localparam logic [3:0] PH_EXTLEN_HI = 4'd7;
	localparam logic [3:0] PH_EXTLEN_LO = 4'd8;
	localparam logic [3:0] PH_EXTHDR    = 4'd9;
	localparam logic [3:0] PH_EXTBODY   = 4'd10;
	localparam logic [3:0] PH_SNI       = 4'd11;
	localparam logic [3:0] PH_NAME      = 4'd12;
	localparam logic [3:0] PH_TAIL      = 4'd13;
	localparam logic [3:0] PH_DONE      = 4'd14;

	localparam logic [1:0] OUT_UNDECIDED = 2'd0;
	localparam logic [1:0] OUT_FOUND     = 2'd1;
	localparam logic [1:0] OUT_FAILED    = 2'd2;

	logic [3:0]                  phase_q, phase_d;
	logic [tsni_pkg::POS_W-1:0]  pos_q, pos_d;
	logic [15:0]                 fr_q, fr_d;
	logic [7:0]                  hi_q, hi_d;
	logic [15:0]                 exts_q, exts_d;
	logic [15:0]                 ext_q, ext_d;
	logic                        type0_q, type0_d;
	logic [tsni_pkg::NAME_W-1:0] nrem_q, nrem_d;
	logic [7:0]                  elen_q, elen_d;
	logic [1:0]                  out_q, out_d;
	logic [15:0]                 v;
	logic                        want_rest;
	logic                        want_next;
	logic                        name_vld;
	logic                        ok;

	assign v = {hi_q, data_byte};

	always_comb begin
		phase_d   = phase_q;
		pos_d     = (pos_q == '1) ? pos_q : pos_q + 1'b1;
		fr_d      = fr_q;
		hi_d      = hi_q;
		exts_d    = exts_q;
		ext_d     = ext_q;
		type0_d   = type0_q;
		nrem_d    = nrem_q;
		elen_d    = elen_q;
		out_d     = out_q;
		want_rest = 1'b0;
		want_next = 1'b0;
		name_vld  = 1'b0;

		// length counters run down on every byte inside the extension list
		if (phase_q inside {[PH_EXTHDR:PH_TAIL]}) begin
			if (exts_q != 16'd0)
				exts_d = exts_q - 16'd1;
			if (phase_q != PH_EXTHDR && ext_q != 16'd0)
				ext_d = ext_q - 16'd1;
		end

		case (phase_q)
			PH_HEAD: begin
				if ((pos_q == tsni_pkg::POS_REC_TYPE && data_byte != tsni_pkg::REC_HANDSHAKE) ||
				    (pos_q == tsni_pkg::POS_VER_MAJ && data_byte != tsni_pkg::VER_MAJOR) ||
				    (pos_q == tsni_pkg::POS_HS_TYPE &&
				     data_byte != tsni_pkg::HS_CLIENT_HELLO)) begin
					phase_d = PH_DONE;
					out_d   = OUT_FAILED;
				end else if (pos_q == tsni_pkg::POS_SID_LEN) begin
					fr_d    = {8'd0, data_byte};
					phase_d = (data_byte != 8'd0) ? PH_SID : PH_CS_HI;
				end
			end
			PH_SID: begin
				fr_d = fr_q - 16'd1;
				if (fr_q == 16'd1)
					phase_d = PH_CS_HI;
			end
			PH_CS_HI: begin
				hi_d    = data_byte;
				phase_d = PH_CS_LO;
			end
			PH_CS_LO: begin
				fr_d    = v;
				phase_d = (v != 16'd0) ? PH_CS : PH_COMPLEN;
			end
			PH_CS: begin
				fr_d = fr_q - 16'd1;
				if (fr_q == 16'd1)
					phase_d = PH_COMPLEN;
			end
			PH_COMPLEN: begin
				fr_d    = {8'd0, data_byte};
				phase_d = (data_byte != 8'd0) ? PH_COMP : PH_EXTLEN_HI;
			end
			PH_COMP: begin
				fr_d = fr_q - 16'd1;
				if (fr_q == 16'd1)
					phase_d = PH_EXTLEN_HI;
			end
			PH_EXTLEN_HI: begin
				hi_d    = data_byte;
				phase_d = PH_EXTLEN_LO;
			end
			PH_EXTLEN_LO: begin
				exts_d    = v;
				want_next = 1'b1;
			end
			PH_EXTHDR: begin
				if (fr_q == 16'd0) begin
					hi_d = data_byte;
					fr_d = 16'd1;
				end else if (fr_q == 16'd1) begin
					type0_d = (v == 16'd0);
					fr_d    = 16'd2;
				end else if (fr_q == 16'd2) begin
					hi_d = data_byte;
					fr_d = 16'd3;
				end else begin
					fr_d = 16'd0;
					if (v > exts_d) begin
						phase_d = PH_DONE;
						out_d   = OUT_FAILED;
					end else if (type0_q && v >= tsni_pkg::SNI_MIN_SIZE) begin
						ext_d   = v;
						phase_d = PH_SNI;
					end else begin
						ext_d     = v;
						want_rest = 1'b1;
					end
				end
			end
			PH_EXTBODY: begin
				if (ext_d == 16'd0)
					want_next = 1'b1;
			end
			PH_SNI: begin
				// list length hi/lo, entry type, name length hi/lo
				if (fr_q == 16'd0 || fr_q == 16'd3) begin
					hi_d = data_byte;
					fr_d = fr_q + 16'd1;
				end else if (fr_q == 16'd1) begin
					if (v > ext_d) begin
						phase_d = PH_DONE;
						out_d   = OUT_FAILED;
					end else begin
						fr_d = 16'd2;
					end
				end else if (fr_q == 16'd2) begin
					if (data_byte != 8'd0)
						want_rest = 1'b1;
					else
						fr_d = 16'd3;
				end else begin
					fr_d = 16'd0;
					if (v != 16'd0 && v <= ext_d &&
					    {1'b0, v} < 17'(tsni_pkg::NAME_LIMIT)) begin
						nrem_d  = v[tsni_pkg::NAME_W-1:0];
						elen_d  = 8'd0;
						phase_d = PH_NAME;
					end else begin
						want_rest = 1'b1;
					end
				end
			end
			PH_NAME: begin
				name_vld = 1'b1;
				elen_d   = elen_q + 8'd1;
				nrem_d   = nrem_q - 1'b1;
				if (nrem_q == tsni_pkg::NAME_W'(1)) begin
					if (ext_d == 16'd0) begin
						phase_d = PH_DONE;
						out_d   = OUT_FOUND;
					end else begin
						phase_d = PH_TAIL;
					end
				end
			end
			PH_TAIL: begin
				if (ext_d == 16'd0) begin
					phase_d = PH_DONE;
					out_d   = OUT_FOUND;
				end
			end
			default: begin
			end
		endcase

		// skip the rest of the current extension, then the next header
		if (want_rest) begin
			if (ext_d == 16'd0)
				want_next = 1'b1;
			else
				phase_d = PH_EXTBODY;
		end
		if (want_next) begin
			if (exts_d >= tsni_pkg::EXT_HDR_SIZE) begin
				phase_d = PH_EXTHDR;
				fr_d    = 16'd0;
			end else begin
				phase_d = PH_DONE;
				out_d   = OUT_FAILED;
			end
		end
	end

	assign ok = (out_d == OUT_FOUND);

	always_comb begin
		res             = '0;
		res.name_vld    = name_vld;
		res.name_byte   = data_byte;
		res.verdict_vld = end_of_payload;
		res.found       = ok;
		res.name_length = ok ? elen_d : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD;
			pos_q   <= '0;
			fr_q    <= '0;
			hi_q    <= '0;
			exts_q  <= '0;
			ext_q   <= '0;
			type0_q <= 1'b1;
			nrem_q  <= '0;
			elen_q  <= '0;
			out_q   <= OUT_UNDECIDED;
		end else if (step) begin
			if (end_of_payload) begin
				// verdict sent: start over for the next payload
				phase_q <= PH_HEAD;
				pos_q   <= '0;
				fr_q    <= '0;
				hi_q    <= '0;
				exts_q  <= '0;
				ext_q   <= '0;
				type0_q <= 1'b1;
				nrem_q  <= '0;
				elen_q  <= '0;
				out_q   <= OUT_UNDECIDED;
			end else begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				fr_q    <= fr_d;
				hi_q    <= hi_d;
				exts_q  <= exts_d;
				ext_q   <= ext_d;
				type0_q <= type0_d;
				nrem_q  <= nrem_d;
				elen_q  <= elen_d;
				out_q   <= out_d;
			end
		end
	end

	`TSE_ASSERT(a_restart_after_verdict, clk, arst_n, step && end_of_payload |=> phase_q == PH_HEAD && elen_q == 8'd0 && out_q == OUT_UNDECIDED, "parser did not restart after verdict")
	`TSE_ASSERT_NEVER(a_name_count_live, clk, arst_n, phase_q == PH_NAME && nrem_q == '0, "name phase with no bytes left")
	`TSE_ASSERT(a_found_is_final, clk, arst_n, out_q == OUT_FOUND |-> phase_q == PH_DONE, "found outcome outside done phase")

endmodule

// ===== hw/rtl/tls_sni_extractor.sv =====
// TLS SNI extractor: takes one payload byte per cycle and returns the server name
// bytes of a ClientHello plus one verdict per payload. A byte is registered in an input
// stage, parsed from there once the queue has room, and its zero, one or two result
// items are written into a 4-entry output queue, in the order produced, name bytes
// ahead of their payload's verdict. The input takes one byte every cycle
// as long as the queue has room for two items; a consumer that takes an item every
// cycle never stalls it, so only a consumer that leaves items waiting holds it back.
// Depends on tsni_pkg, tsni_parser and tls_sni_extractor_macros.svh.
`timescale 1ns / 1ps
`include "tls_sni_extractor_macros.svh"

module tls_sni_extractor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_payload,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_verdict,
	output logic [7:0] name_byte,
	output logic       found,
	output logic [7:0] name_length
);

	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	logic                        last_s1;
	logic                        advance;
	logic                        pop;
	logic [tsni_pkg::QCNT_W:0]   free;
	logic [1:0]                  push_n;
	tsni_pkg::step_res_t         res;
	tsni_pkg::out_item_t         item0, item1, verdict_item;
	tsni_pkg::out_item_t         queue_q [tsni_pkg::QDEPTH];
	logic [tsni_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [tsni_pkg::QCNT_W-1:0] count_q;

	assign pop     = out_valid && out_ready;
	assign free    = (tsni_pkg::QCNT_W+1)'(tsni_pkg::QDEPTH) - {1'b0, count_q}
	                 + {{tsni_pkg::QCNT_W{1'b0}}, pop};
	assign advance = valid_s1 && (free >= (tsni_pkg::QCNT_W+1)'(2));
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_valid && in_ready)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= end_of_payload;
		end
	end

	tsni_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.data_byte      (byte_s1),
		.end_of_payload (last_s1),
		.res            (res)
	);

	always_comb begin
		verdict_item.is_verdict  = 1'b1;
		verdict_item.name_byte   = 8'd0;
		verdict_item.found       = res.found;
		verdict_item.name_length = res.name_length;
		item0 = verdict_item;
		if (res.name_vld) begin
			item0.is_verdict  = 1'b0;
			item0.name_byte   = res.name_byte;
			item0.found       = 1'b0;
			item0.name_length = 8'd0;
		end
		item1  = verdict_item;
		push_n = {1'b0, res.name_vld} + {1'b0, res.verdict_vld};
	end

	assign wr_ptr_nx = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (advance && push_n != 2'd0)
			queue_q[wr_ptr_q] <= item0;
		if (advance && push_n == 2'd2)
			queue_q[wr_ptr_nx] <= item1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (advance)
				wr_ptr_q <= wr_ptr_q + tsni_pkg::QPTR_W'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (advance ? tsni_pkg::QCNT_W'(push_n) : '0)
			           - tsni_pkg::QCNT_W'(pop);
		end
	end

	assign out_valid   = (count_q != '0);
	assign is_verdict  = queue_q[rd_ptr_q].is_verdict;
	assign name_byte   = queue_q[rd_ptr_q].name_byte;
	assign found       = queue_q[rd_ptr_q].found;
	assign name_length = queue_q[rd_ptr_q].name_length;

	`TSE_ASSERT_NEVER(a_queue_overflow, clk, arst_n, count_q > tsni_pkg::QCNT_W'(tsni_pkg::QDEPTH), "output queue count above depth")
	`TSE_ASSERT(a_stalled_byte_held, clk, arst_n, valid_s1 && !advance |=> valid_s1, "stalled byte dropped")
	`TSE_ASSERT(a_full_blocks, clk, arst_n, count_q == tsni_pkg::QCNT_W'(tsni_pkg::QDEPTH) |-> !advance, "parser advanced into a full queue")

endmodule

// ===== test/tls_sni_checker.sv =====
`timescale 1ns / 1ps
// Result checker for tls_sni_extractor: tracks accepted payload bytes, predicts
// the name and verdict items they produce and compares them in order.
// Depends on tsni_pkg.

module tls_sni_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       end_of_payload,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       is_verdict,
	input  logic [7:0] name_byte,
	input  logic       found,
	input  logic [7:0] name_length,
	output int         errors,
	output int         waiting,
	output int         checked,
	output int         names_found
);

	typedef enum logic [3:0] {
		S_HEADER, S_SESSION, S_SUITES_HI, S_SUITES_LO, S_SUITES, S_COMP_LEN, S_COMP,
		S_EXTS_HI, S_EXTS_LO, S_EXT_HDR, S_EXT_BODY, S_SNI_HDR, S_NAME, S_SNI_TAIL,
		S_DONE
	} stage_t;

	typedef enum logic [1:0] {ST_OPEN, ST_FOUND, ST_FAILED} status_t;

	localparam logic [16:0] OFFSET_MAX = 17'h1FFFF;

	stage_t      stage;
	status_t     status;
	logic [16:0] offset;
	logic [15:0] skip_left;
	logic [7:0]  high_byte;
	logic [15:0] list_left;
	logic [15:0] ext_left;
	logic [15:0] ext_kind;
	logic [15:0] name_left;
	logic [7:0]  name_count;

	tsni_pkg::out_item_t due_items[$];
	tsni_pkg::out_item_t want;

	task automatic clear_parser();
		stage      = S_HEADER;
		status     = ST_OPEN;
		offset     = '0;
		skip_left  = '0;
		high_byte  = '0;
		list_left  = '0;
		ext_left   = '0;
		ext_kind   = '0;
		name_left  = '0;
		name_count = '0;
	endtask

	task automatic conclude(input status_t st);
		stage  = S_DONE;
		status = st;
	endtask

	task automatic begin_skip(input logic [15:0] n, input stage_t busy, input stage_t after);
		skip_left = n;
		stage     = (n != 0) ? busy : after;
	endtask

	task automatic open_next_ext();
		if (list_left >= tsni_pkg::EXT_HDR_SIZE) begin
			stage     = S_EXT_HDR;
			skip_left = '0;
		end else
			conclude(ST_FAILED);
	endtask

	task automatic finish_ext();
		if (ext_left == 0)
			open_next_ext();
		else
			stage = S_EXT_BODY;
	endtask

	// advance the parser by one payload byte and queue the items it yields
	task automatic predict_byte(input logic [7:0] b, input logic last);
		logic [15:0]         v;
		tsni_pkg::out_item_t item;
		v = {high_byte, b};
		if (stage >= S_EXT_HDR && stage <= S_SNI_TAIL) begin
			if (list_left != 0)
				list_left = list_left - 16'd1;
			if (stage != S_EXT_HDR && ext_left != 0)
				ext_left = ext_left - 16'd1;
		end
		case (stage)
			S_HEADER: begin
				if ((offset == tsni_pkg::POS_REC_TYPE && b != tsni_pkg::REC_HANDSHAKE) ||
				    (offset == tsni_pkg::POS_VER_MAJ && b != tsni_pkg::VER_MAJOR) ||
				    (offset == tsni_pkg::POS_HS_TYPE && b != tsni_pkg::HS_CLIENT_HELLO))
					conclude(ST_FAILED);
				else if (offset == tsni_pkg::POS_SID_LEN)
					begin_skip({8'd0, b}, S_SESSION, S_SUITES_HI);
			end
			S_SESSION, S_SUITES, S_COMP: begin
				skip_left = skip_left - 16'd1;
				if (skip_left == 0)
					stage = (stage == S_SESSION) ? S_SUITES_HI :
					        (stage == S_SUITES) ? S_COMP_LEN : S_EXTS_HI;
			end
			S_SUITES_HI, S_EXTS_HI: begin
				high_byte = b;
				stage = (stage == S_SUITES_HI) ? S_SUITES_LO : S_EXTS_LO;
			end
			S_SUITES_LO: begin_skip(v, S_SUITES, S_COMP_LEN);
			S_COMP_LEN: begin_skip({8'd0, b}, S_COMP, S_EXTS_HI);
			S_EXTS_LO: begin
				list_left = v;
				open_next_ext();
			end
			S_EXT_HDR: begin
				if (skip_left == 0 || skip_left == 2) begin
					high_byte = b;
					skip_left = skip_left + 16'd1;
				end else if (skip_left == 1) begin
					ext_kind  = v;
					skip_left = 16'd2;
				end else begin
					skip_left = '0;
					ext_left  = v;
					if (v > list_left)
						conclude(ST_FAILED);
					else if (ext_kind == 0 && v >= tsni_pkg::SNI_MIN_SIZE)
						stage = S_SNI_HDR;
					else
						finish_ext();
				end
			end
			S_EXT_BODY: begin
				if (ext_left == 0)
					open_next_ext();
			end
			S_SNI_HDR: begin
				if (skip_left == 0 || skip_left == 3) begin
					high_byte = b;
					skip_left = skip_left + 16'd1;
				end else if (skip_left == 1) begin
					// a name list longer than the extension is fatal
					if (v > ext_left)
						conclude(ST_FAILED);
					else
						skip_left = 16'd2;
				end else if (skip_left == 2) begin
					if (b != 0)
						finish_ext();
					else
						skip_left = 16'd3;
				end else begin
					skip_left = '0;
					if (v != 0 && v <= ext_left && 32'(v) < tsni_pkg::NAME_LIMIT) begin
						name_left  = v;
						name_count = '0;
						stage      = S_NAME;
					end else
						finish_ext();
				end
			end
			S_NAME: begin
				item = '0;
				item.name_byte = b;
				due_items.push_back(item);
				name_count = name_count + 8'd1;
				name_left  = name_left - 16'd1;
				if (name_left == 0) begin
					if (ext_left == 0)
						conclude(ST_FOUND);
					else
						stage = S_SNI_TAIL;
				end
			end
			S_SNI_TAIL: begin
				if (ext_left == 0)
					conclude(ST_FOUND);
			end
			default: ;
		endcase
		if (offset != OFFSET_MAX)
			offset = offset + 17'd1;
		if (last) begin
			item = '0;
			item.is_verdict = 1'b1;
			if (status == ST_FOUND) begin
				item.found       = 1'b1;
				item.name_length = name_count;
			end
			due_items.push_back(item);
			clear_parser();
		end
	endtask

	task automatic check_field(input string what, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			due_items.delete();
			errors      = 0;
			checked     = 0;
			names_found = 0;
		end else begin
			if (in_valid && in_ready)
				predict_byte(data_byte, end_of_payload);
			if (out_valid && out_ready) begin
				if (due_items.size() == 0) begin
					$display("%0t: unexpected item, expected none, %s %0d %0d %0d %0d",
						$time, "got verdict/byte/found/len", is_verdict, name_byte,
						found, name_length);
					errors++;
				end else begin
					want = due_items.pop_front();
					check_field("is_verdict", want.is_verdict, is_verdict);
					check_field("name_byte", want.name_byte, name_byte);
					check_field("found", want.found, found);
					check_field("name_length", want.name_length, name_length);
					checked++;
					if (want.is_verdict && want.found)
						names_found++;
				end
			end
		end
		waiting = due_items.size();
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the tls_sni_extractor test: builds ClientHello payloads, good and broken,
// and feeds them byte by byte. Depends on tsni_pkg, tls_sni_checker and the RTL.

module testbench;

	logic       clk            = 1'b0;
	logic       arst_n         = 1'b0;
	logic       in_valid       = 1'b0;
	logic [7:0] data_byte      = 8'd0;
	logic       end_of_payload = 1'b0;
	logic       out_ready      = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic       is_verdict;
	logic [7:0] name_byte;
	logic       found;
	logic [7:0] name_length;

	int errors;
	int waiting;
	int checked;
	int names_found;
	int bytes_sent    = 0;
	int payloads_sent = 0;
	bit calm          = 1'b0;

	logic [7:0] pay[$];
	logic [7:0] ext_bytes[$];

	tls_sni_extractor uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .end_of_payload(end_of_payload),
		.out_valid(out_valid), .out_ready(out_ready),
		.is_verdict(is_verdict), .name_byte(name_byte),
		.found(found), .name_length(name_length)
	);

	tls_sni_checker sni_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .end_of_payload(end_of_payload),
		.out_valid(out_valid), .out_ready(out_ready),
		.is_verdict(is_verdict), .name_byte(name_byte),
		.found(found), .name_length(name_length),
		.errors(errors), .waiting(waiting), .checked(checked), .names_found(names_found)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk)
		out_ready <= calm || ($urandom_range(0, 99) >= 18);

	initial begin
		#400_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		logic rdy;
		if (!calm && $urandom_range(0, 99) < 18) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < 30)
				@(posedge clk);
		end
		in_valid       <= 1'b1;
		data_byte      <= b;
		end_of_payload <= last;
		// sample ready mid-cycle, when it is settled
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
		bytes_sent++;
	endtask

	task automatic send_payload();
		for (int i = 0; i < pay.size(); i++)
			send_byte(pay[i], i == pay.size() - 1);
		payloads_sent++;
	endtask

	// hold the input until every expected item has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (waiting != 0);
		@(posedge clk);
	endtask

	task automatic ext_word(input logic [15:0] w);
		ext_bytes.push_back(w[15:8]);
		ext_bytes.push_back(w[7:0]);
	endtask

	task automatic add_ext(input logic [15:0] kind, input int size);
		ext_word(kind);
		ext_word(16'(size));
		repeat (size) ext_bytes.push_back(8'($urandom));
	endtask

	// SNI extension: one entry, name length field may disagree with the bytes
	task automatic add_sni(input logic [7:0] entry, input int len_field, input int name_bytes,
			input int extra, input int list_adj);
		int entries_len;
		entries_len = 3 + name_bytes + list_adj;
		if (entries_len < 0)
			entries_len = 0;
		ext_word(16'd0);
		ext_word(16'(5 + name_bytes + extra));
		ext_word(16'(entries_len));
		ext_bytes.push_back(entry);
		ext_word(16'(len_field));
		repeat (name_bytes + extra) ext_bytes.push_back(8'($urandom));
	endtask

	// keep: 0 all, -1 random cut, else exact byte count; bad_pos < 0 leaves header intact
	task automatic make_hello(input int sid_len, input int cs_len, input int cmeth_len,
			input int list_delta, input int keep, input int pad, input int bad_pos);
		int ext_total;
		pay.delete();
		pay.push_back(tsni_pkg::REC_HANDSHAKE);
		pay.push_back(tsni_pkg::VER_MAJOR);
		repeat (3) pay.push_back(8'($urandom));
		pay.push_back(tsni_pkg::HS_CLIENT_HELLO);
		repeat (35) pay.push_back(8'($urandom));
		pay.push_back(8'(sid_len));
		repeat (sid_len) pay.push_back(8'($urandom));
		pay.push_back(8'(cs_len >> 8));
		pay.push_back(8'(cs_len));
		repeat (cs_len) pay.push_back(8'($urandom));
		pay.push_back(8'(cmeth_len));
		repeat (cmeth_len) pay.push_back(8'($urandom));
		ext_total = ext_bytes.size() + list_delta;
		if (ext_total < 0)
			ext_total = 0;
		pay.push_back(8'(ext_total >> 8));
		pay.push_back(8'(ext_total));
		foreach (ext_bytes[i])
			pay.push_back(ext_bytes[i]);
		ext_bytes.delete();
		if (bad_pos >= 0)
			pay[bad_pos] = pay[bad_pos] ^ 8'($urandom_range(1, 255));
		if (keep < 0)
			keep = $urandom_range(1, pay.size() - 1);
		if (keep > 0)
			while (pay.size() > keep)
				void'(pay.pop_back());
		repeat (pad) pay.push_back(8'($urandom));
		send_payload();
	endtask

	task automatic noise_payload();
		int n;
		n = $urandom_range(1, 50);
		pay.delete();
		repeat (n) pay.push_back(8'($urandom));
		if (n > 1 && $urandom_range(0, 1)) begin
			pay[0] = tsni_pkg::REC_HANDSHAKE;
			pay[1] = tsni_pkg::VER_MAJOR;
		end
		send_payload();
	endtask

	task automatic random_hello();
		int kind, nlen, extra, sid_len, cs_len, delta, bad_pos;
		repeat ($urandom_range(0, 4)) begin
			kind  = $urandom_range(0, 99);
			nlen  = ($urandom_range(0, 29) == 0) ? $urandom_range(200, 255) : $urandom_range(1, 24);
			extra = $urandom_range(0, 3);
			if (kind < 40)
				add_sni(8'd0, nlen, nlen, extra, $urandom_range(0, extra));
			else if (kind < 50)
				add_ext(16'($urandom_range(1, 65535)), $urandom_range(0, 8));
			else if (kind < 56)
				add_ext(16'($urandom_range(1, 255)), $urandom_range(0, 8));
			else if (kind < 63)
				add_ext(16'd0, $urandom_range(0, 4));
			else if (kind < 71)
				add_sni(8'($urandom_range(1, 255)), nlen, nlen, extra, 0);
			else if (kind < 77)
				add_sni(8'd0, 0, extra, 0, 0);
			else if (kind < 84)
				add_sni(8'd0, nlen + extra + $urandom_range(1, 4), nlen, extra, 0);
			else if (kind < 91)
				add_sni(8'd0, nlen, nlen, extra, extra + $urandom_range(1, 4));
			else if (kind < 92)
				add_sni(8'd0, tsni_pkg::NAME_LIMIT, tsni_pkg::NAME_LIMIT, 0, 0);
			else
				add_ext(16'($urandom), $urandom_range(0, 8));
		end
		sid_len = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 255) : $urandom_range(0, 4);
		cs_len  = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 6);
		case ($urandom_range(0, 9))
			0: delta = -$urandom_range(1, 6);
			1: delta = $urandom_range(1, 6);
			default: delta = 0;
		endcase
		case ($urandom_range(0, 59))
			0: bad_pos = tsni_pkg::POS_REC_TYPE;
			1: bad_pos = tsni_pkg::POS_VER_MAJ;
			2: bad_pos = tsni_pkg::POS_HS_TYPE;
			default: bad_pos = -1;
		endcase
		make_hello(sid_len, cs_len, $urandom_range(0, 3), delta,
			($urandom_range(0, 9) == 0) ? -1 : 0,
			($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0, bad_pos);
	endtask

	task automatic random_run(input int count);
		int goal;
		goal = bytes_sent + count;
		while (bytes_sent < goal) begin
			if ($urandom_range(0, 99) < 12)
				noise_payload();
			else
				random_hello();
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// early ends and header faults
		make_hello(0, 0, 0, 0, 1, 0, -1);
		make_hello(0, 0, 0, 0, 42, 0, -1);
		add_sni(8'd0, 3, 3, 0, 0);
		make_hello(0, 0, 0, 0, 12, 0, tsni_pkg::POS_REC_TYPE);
		add_sni(8'd0, 3, 3, 0, 0);
		make_hello(0, 0, 0, 0, 12, 2, tsni_pkg::POS_VER_MAJ);
		add_sni(8'd0, 3, 3, 0, 0);
		make_hello(0, 0, 0, 0, 12, 4, tsni_pkg::POS_HS_TYPE);
		// shortest usable name, then a name at the limit skipped before the longest one
		add_sni(8'd0, 1, 1, 0, 0);
		make_hello(0, 0, 0, 0, 0, 0, -1);
		add_sni(8'd0, tsni_pkg::NAME_LIMIT, tsni_pkg::NAME_LIMIT, 0, 0);
		add_sni(8'd0, 255, 255, 2, 2);
		make_hello(2, 4, 1, 0, 0, 0, -1);
		// unusable entries get skipped
		add_sni(8'h01, 4, 4, 0, 0);
		add_sni(8'd0, 6, 6, 1, 0);
		make_hello(0, 2, 1, 0, 0, 0, -1);
		add_sni(8'd0, 0, 2, 0, 0);
		add_sni(8'd0, 3, 3, 0, 0);
		make_hello(0, 0, 0, 0, 0, 0, -1);
		add_ext(16'd0, 4);
		add_ext(16'h0010, 0);
		add_sni(8'd0, 5, 5, 3, 1);
		make_hello(0, 0, 0, 0, 0, 0, -1);
		add_sni(8'd0, 9, 4, 0, 0);
		add_sni(8'd0, 2, 2, 0, 0);
		make_hello(0, 0, 0, 0, 0, 0, -1);
		// malformed lists and extensions
		add_sni(8'd0, 4, 4, 1, 2);
		make_hello(0, 0, 0, 0, 0, 0, -1);
		add_ext(16'h002b, 6);
		make_hello(0, 0, 0, -1, 0, 0, -1);
		make_hello(0, 0, 0, 3, 0, 0, -1);
		make_hello(0, 0, 0, 0, 0, 0, -1);
		add_ext(16'h000a, 2);
		make_hello(0, 0, 0, 2, 0, 0, -1);
		// cut inside the name, then bytes after a found name
		add_sni(8'd0, 10, 10, 0, 0);
		make_hello(0, 0, 0, 0, 60, 0, -1);
		add_sni(8'd0, 7, 7, 0, 0);
		make_hello(2, 4, 1, 0, 0, 5, -1);
		drain();

		random_run(80);
		drain();

		// stretch without idling on either side
		calm = 1'b1;
		add_sni(8'd0, 8, 8, 0, 0);
		make_hello(0, 2, 1, 0, 0, 5, -1);
		random_run(120);
		calm = 1'b0;
		drain();

		random_run(80);
		drain();
		repeat (20) @(posedge clk);

		$display("Sent %0d payloads, %0d bytes: %s",
			payloads_sent, bytes_sent,
			"header faults, cuts, skipped and broken extensions.");
		$display("Checked %0d result items; %0d payloads yielded a server name.",
			checked, names_found);
		if (errors == 0 && waiting == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tsni_pkg.sv
hw/rtl/tsni_parser.sv
hw/rtl/tls_sni_extractor.sv
test/tls_sni_checker.sv
test/testbench.sv
